FILE: hdl/bbvs_pkg.sv
package bbvs_pkg;

    // field widths
    localparam int COORD_W   = 32;
    localparam int INDEX_W   = 10;
    localparam int PAPER_W   = 8;
    localparam int QUOT_W    = 24;
    localparam int PROD_W    = COORD_W + PAPER_W;
    localparam int FRAC_W    = 16;
    localparam int STEP_W    = 5;

    // serial unit step counts: one paper bit, then one quotient bit per cycle
    localparam int MUL_STEPS = PAPER_W;
    localparam int DIV_STEPS = QUOT_W;

    localparam int                MAX_POINTS_DEF = 1024;
    localparam logic [PAPER_W-1:0] PAPER_RESET   = 8'd6;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_LINE   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NOT_LOADED = 2'd1;
    localparam logic [1:0] STAT_ZERO_RANGE = 2'd2;
    localparam logic [1:0] STAT_FULL       = 2'd3;

    // pen codes
    localparam logic PEN_MOVE = 1'b0;
    localparam logic PEN_DRAW = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_low;
        logic signed [COORD_W-1:0] x_high;
        logic signed [COORD_W-1:0] y_low;
        logic signed [COORD_W-1:0] y_high;
    } t_bounds;

    typedef struct packed {
        logic                      go;
        logic signed [COORD_W-1:0] value;
        logic signed [COORD_W-1:0] low;
        logic signed [COORD_W-1:0] high;
        logic [PAPER_W-1:0]        paper;
    } t_lane_cmd;

endpackage

FILE: hdl/bounding_box_viewport_scaler_unit.sv
// Line item: the store read, a go pulse to the lanes, then the 8-step serial multiply
// and the 24-step serial divide, four lanes in parallel, lead to the move beat; the draw
// beat follows in the cycle after it. Busy until the draw beat; no new item is taken before.
// Append, clear and ignored ops never set busy; a full-store append gives its beat next cycle.
// Synchronous active-low reset clears count, bounds and control; paper size returns to 6.
// Results are strobed for one cycle each; the receiver cannot stall.
module bounding_box_viewport_scaler_unit #(
    parameter int MAX_POINTS = bbvs_pkg::MAX_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bbvs_pkg::PAPER_W-1:0]        i_cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_op,
    input  logic signed [bbvs_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [bbvs_pkg::COORD_W-1:0] i_y_coord,
    input  logic [bbvs_pkg::INDEX_W-1:0]        i_start_index,
    input  logic [bbvs_pkg::INDEX_W-1:0]        i_end_index,
    output logic                                o_strobe,
    output logic                                o_pen_kind,
    output logic [bbvs_pkg::QUOT_W-1:0]         o_graph_x,
    output logic [bbvs_pkg::QUOT_W-1:0]         o_graph_y,
    output logic [1:0]                          o_status,
    output logic                                o_last
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CMP_W  = (CNT_W > bbvs_pkg::INDEX_W) ? CNT_W : bbvs_pkg::INDEX_W;
    localparam int LANES  = 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_DRAW
    } t_state;

    t_state                        r_state;
    logic [bbvs_pkg::PAPER_W-1:0]  r_paper_size;
    logic                          r_go;
    logic [1:0]                    r_st_start;
    logic [1:0]                    r_st_end;
    logic                          r_strobe;
    logic                          r_pen_kind;
    logic [bbvs_pkg::QUOT_W-1:0]   r_graph_x;
    logic [bbvs_pkg::QUOT_W-1:0]   r_graph_y;
    logic [1:0]                    r_status;
    logic                          r_last;

    logic                          w_accept;
    logic                          w_append;
    logic                          w_clear;
    logic                          w_line;
    logic                          w_full;
    logic                          w_zero_range;
    logic                          w_done;
    logic [CNT_W-1:0]              w_count;
    bbvs_pkg::t_bounds             w_bounds;
    bbvs_pkg::t_point              w_wdata;
    bbvs_pkg::t_point              w_pt_start;
    bbvs_pkg::t_point              w_pt_end;
    bbvs_pkg::t_lane_cmd           w_cmd  [LANES];
    logic [bbvs_pkg::QUOT_W-1:0]   w_quot [LANES];
    logic [LANES-1:0]              w_lane_done;
    logic [1:0]                    n_st_start;
    logic [1:0]                    n_st_end;

    // handshake decode
    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_append = w_accept && (i_op == bbvs_pkg::OP_APPEND) && !w_full;
    assign w_clear  = w_accept && (i_op == bbvs_pkg::OP_CLEAR);
    assign w_line   = w_accept && (i_op == bbvs_pkg::OP_LINE);

    // paper size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paper_size <= bbvs_pkg::PAPER_RESET;
        end else if (i_cfg_we) begin
            r_paper_size <= i_cfg_wdata;
        end
    end

    bbvs_bounds_tracker #(
        .MAX_POINTS (MAX_POINTS),
        .CNT_W      (CNT_W)
    ) u_bounds (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_append (w_append),
        .i_clear  (w_clear),
        .i_x      (i_x_coord),
        .i_y      (i_y_coord),
        .o_count  (w_count),
        .o_full   (w_full),
        .o_bounds (w_bounds)
    );

    assign w_wdata.x = i_x_coord;
    assign w_wdata.y = i_y_coord;

    bbvs_point_store #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_append),
        .i_waddr   (w_count[ADDR_W-1:0]),
        .i_wdata   (w_wdata),
        .i_re      (w_line),
        .i_raddr_a (ADDR_W'(i_start_index)),
        .i_raddr_b (ADDR_W'(i_end_index)),
        .o_rdata_a (w_pt_start),
        .o_rdata_b (w_pt_end)
    );

    // per-point status, decided from count and bounds at accept
    assign w_zero_range = (w_bounds.x_high == w_bounds.x_low)
                       || (w_bounds.y_high == w_bounds.y_low);

    always_comb begin
        if (CMP_W'(i_start_index) >= CMP_W'(w_count)) begin
            n_st_start = bbvs_pkg::STAT_NOT_LOADED;
        end else if (w_zero_range) begin
            n_st_start = bbvs_pkg::STAT_ZERO_RANGE;
        end else begin
            n_st_start = bbvs_pkg::STAT_OK;
        end
        if (CMP_W'(i_end_index) >= CMP_W'(w_count)) begin
            n_st_end = bbvs_pkg::STAT_NOT_LOADED;
        end else if (w_zero_range) begin
            n_st_end = bbvs_pkg::STAT_ZERO_RANGE;
        end else begin
            n_st_end = bbvs_pkg::STAT_OK;
        end
    end

    // lane commands: start x, start y, end x, end y
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_cmd[i].go    = r_go;
            w_cmd[i].paper = r_paper_size;
        end
        w_cmd[0].value = w_pt_start.x;
        w_cmd[0].low   = w_bounds.x_low;
        w_cmd[0].high  = w_bounds.x_high;
        w_cmd[1].value = w_pt_start.y;
        w_cmd[1].low   = w_bounds.y_low;
        w_cmd[1].high  = w_bounds.y_high;
        w_cmd[2].value = w_pt_end.x;
        w_cmd[2].low   = w_bounds.x_low;
        w_cmd[2].high  = w_bounds.x_high;
        w_cmd[3].value = w_pt_end.y;
        w_cmd[3].low   = w_bounds.y_low;
        w_cmd[3].high  = w_bounds.y_high;
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bbvs_serial_scaler u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[g]),
            .o_quot  (w_quot[g]),
            .o_done  (w_lane_done[g])
        );
    end

    assign w_done = &w_lane_done;

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_go     <= 1'b0;
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_op == bbvs_pkg::OP_APPEND) && w_full) begin
                        r_strobe   <= 1'b1;
                        r_pen_kind <= bbvs_pkg::PEN_MOVE;
                        r_graph_x  <= '0;
                        r_graph_y  <= '0;
                        r_status   <= bbvs_pkg::STAT_FULL;
                        r_last     <= 1'b1;
                    end
                    if (w_line) begin
                        r_st_start <= n_st_start;
                        r_st_end   <= n_st_end;
                        r_state    <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // store data is registered now
                    r_go    <= 1'b1;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (w_done) begin
                        r_strobe   <= 1'b1;
                        r_pen_kind <= bbvs_pkg::PEN_MOVE;
                        r_graph_x  <= (r_st_start == bbvs_pkg::STAT_OK) ? w_quot[0] : '0;
                        r_graph_y  <= (r_st_start == bbvs_pkg::STAT_OK) ? w_quot[1] : '0;
                        r_status   <= r_st_start;
                        r_last     <= 1'b0;
                        r_state    <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    r_strobe   <= 1'b1;
                    r_pen_kind <= bbvs_pkg::PEN_DRAW;
                    r_graph_x  <= (r_st_end == bbvs_pkg::STAT_OK) ? w_quot[2] : '0;
                    r_graph_y  <= (r_st_end == bbvs_pkg::STAT_OK) ? w_quot[3] : '0;
                    r_status   <= r_st_end;
                    r_last     <= 1'b1;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe   = r_strobe;
    assign o_pen_kind = r_pen_kind;
    assign o_graph_x  = r_graph_x;
    assign o_graph_y  = r_graph_y;
    assign o_status   = r_status;
    assign o_last     = r_last;

endmodule

FILE: hdl/bbvs_point_store.sv
module bbvs_point_store #(
    parameter int DEPTH  = bbvs_pkg::MAX_POINTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  bbvs_pkg::t_point      i_wdata,
    input  logic                  i_re,
    input  logic [ADDR_W-1:0]     i_raddr_a,
    input  logic [ADDR_W-1:0]     i_raddr_b,
    output bbvs_pkg::t_point      o_rdata_a,
    output bbvs_pkg::t_point      o_rdata_b
);

    bbvs_pkg::t_point r_mem [DEPTH];
    bbvs_pkg::t_point r_rdata_a;
    bbvs_pkg::t_point r_rdata_b;

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // two registered read ports, held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: hdl/bbvs_bounds_tracker.sv
module bbvs_bounds_tracker #(
    parameter int MAX_POINTS = bbvs_pkg::MAX_POINTS_DEF,
    parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_append,
    input  logic                                i_clear,
    input  logic signed [bbvs_pkg::COORD_W-1:0] i_x,
    input  logic signed [bbvs_pkg::COORD_W-1:0] i_y,
    output logic [CNT_W-1:0]                    o_count,
    output logic                                o_full,
    output bbvs_pkg::t_bounds                   o_bounds
);

    logic [CNT_W-1:0]  r_count;
    bbvs_pkg::t_bounds r_bounds;

    // point count and running min/max; first point seeds all four bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count  <= '0;
            r_bounds <= '0;
        end else if (i_append) begin
            r_count <= r_count + CNT_W'(1);
            if (r_count == '0) begin
                r_bounds.x_low  <= i_x;
                r_bounds.x_high <= i_x;
                r_bounds.y_low  <= i_y;
                r_bounds.y_high <= i_y;
            end else begin
                if (i_x < r_bounds.x_low)  r_bounds.x_low  <= i_x;
                if (i_x > r_bounds.x_high) r_bounds.x_high <= i_x;
                if (i_y < r_bounds.y_low)  r_bounds.y_low  <= i_y;
                if (i_y > r_bounds.y_high) r_bounds.y_high <= i_y;
            end
        end
    end

    assign o_count  = r_count;
    assign o_full   = (r_count == CNT_W'(MAX_POINTS));
    assign o_bounds = r_bounds;

endmodule

FILE: hdl/bbvs_serial_scaler.sv
module bbvs_serial_scaler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bbvs_pkg::t_lane_cmd                i_cmd,
    output logic [bbvs_pkg::QUOT_W-1:0]        o_quot,
    output logic                               o_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } t_state;

    t_state                              r_state;
    logic [bbvs_pkg::STEP_W-1:0]         r_cnt;
    logic                                r_done;
    logic [bbvs_pkg::COORD_W-1:0]        r_diff;
    logic [bbvs_pkg::COORD_W-1:0]        r_range;
    logic [bbvs_pkg::PAPER_W-1:0]        r_paper;
    logic [bbvs_pkg::PROD_W-1:0]         r_acc;
    logic [bbvs_pkg::COORD_W-1:0]        r_rem;
    logic [bbvs_pkg::QUOT_W-1:0]         r_sh;

    logic [bbvs_pkg::COORD_W:0]          w_diff;
    logic [bbvs_pkg::COORD_W:0]          w_range;
    logic [bbvs_pkg::PROD_W-1:0]         n_acc;
    logic [bbvs_pkg::COORD_W:0]          w_trial;
    logic [bbvs_pkg::COORD_W:0]          w_sub;
    logic                                w_fit;
    logic [bbvs_pkg::COORD_W-1:0]        n_rem;

    // value - low and high - low, both fit 32 bits unsigned
    assign w_diff  = {i_cmd.value[bbvs_pkg::COORD_W-1], i_cmd.value}
                   - {i_cmd.low[bbvs_pkg::COORD_W-1], i_cmd.low};
    assign w_range = {i_cmd.high[bbvs_pkg::COORD_W-1], i_cmd.high}
                   - {i_cmd.low[bbvs_pkg::COORD_W-1], i_cmd.low};

    // shift-add multiply, paper MSB first
    assign n_acc = {r_acc[bbvs_pkg::PROD_W-2:0], 1'b0}
                 + (r_paper[bbvs_pkg::PAPER_W-1]
                    ? {{bbvs_pkg::PAPER_W{1'b0}}, r_diff} : '0);

    // restoring division step: one quotient bit per cycle
    assign w_trial = {r_rem, r_sh[bbvs_pkg::QUOT_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_range});
    assign w_sub   = w_trial - {1'b0, r_range};
    assign n_rem   = w_fit ? w_sub[bbvs_pkg::COORD_W-1:0]
                           : w_trial[bbvs_pkg::COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.go) begin
                        r_diff  <= w_diff[bbvs_pkg::COORD_W-1:0];
                        r_range <= w_range[bbvs_pkg::COORD_W-1:0];
                        r_paper <= i_cmd.paper;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc   <= n_acc;
                    r_paper <= {r_paper[bbvs_pkg::PAPER_W-2:0], 1'b0};
                    if (r_cnt == bbvs_pkg::STEP_W'(bbvs_pkg::MUL_STEPS - 1)) begin
                        // quotient < 2^24, so the top product bits start the remainder
                        r_rem   <= n_acc[bbvs_pkg::PROD_W-1:bbvs_pkg::PAPER_W];
                        r_sh    <= {n_acc[bbvs_pkg::PAPER_W-1:0],
                                    {bbvs_pkg::FRAC_W{1'b0}}};
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + bbvs_pkg::STEP_W'(1);
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_sh  <= {r_sh[bbvs_pkg::QUOT_W-2:0], w_fit};
                    if (r_cnt == bbvs_pkg::STEP_W'(bbvs_pkg::DIV_STEPS - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + bbvs_pkg::STEP_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_quot = r_sh;
    assign o_done = r_done;

endmodule

FILE: hdl/bbvs_port_checker.sv
module bbvs_port_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          i_op,
    input  logic                                o_strobe,
    input  logic                                o_pen_kind,
    input  logic [bbvs_pkg::QUOT_W-1:0]         o_graph_x,
    input  logic [bbvs_pkg::QUOT_W-1:0]         o_graph_y,
    input  logic [1:0]                          o_status,
    input  logic                                o_last
);

    // a move beat that is not last is followed at once by the draw beat
    a_move_then_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_pen_kind == bbvs_pkg::PEN_MOVE) && !o_last
        |=> o_strobe && (o_pen_kind == bbvs_pkg::PEN_DRAW) && o_last)
        else $error("move beat not followed by draw beat");

    // any error status carries zero coordinates
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != bbvs_pkg::STAT_OK)
        |-> (o_graph_x == '0) && (o_graph_y == '0))
        else $error("error beat with nonzero position");

    // a full-store beat is a lone last move
    a_full_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == bbvs_pkg::STAT_FULL)
        |-> o_last && (o_pen_kind == bbvs_pkg::PEN_MOVE))
        else $error("full-store beat malformed");

    // an accepted line item makes the block busy
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_op == bbvs_pkg::OP_LINE) |=> busy)
        else $error("line item accepted without going busy");

    // reset leaves the block idle with no beat
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("beat or busy right after reset");

endmodule

bind bounding_box_viewport_scaler_unit bbvs_port_checker u_port_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_op       (i_op),
    .o_strobe   (o_strobe),
    .o_pen_kind (o_pen_kind),
    .o_graph_x  (o_graph_x),
    .o_graph_y  (o_graph_y),
    .o_status   (o_status),
    .o_last     (o_last)
);

FILE: test/bounding_box_viewport_scaler_unit_tb.sv
`timescale 1ns / 1ps

module bounding_box_viewport_scaler_unit_tb;

    localparam int         STORE_DEPTH   = bbvs_pkg::MAX_POINTS_DEF;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         GAP_MAX       = 17;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         RANDOM_ITEMS  = 450;
    localparam int         MAX_REPORTS   = 40;

    typedef struct packed {
        logic                        pen;
        logic [bbvs_pkg::QUOT_W-1:0] gx;
        logic [bbvs_pkg::QUOT_W-1:0] gy;
        logic [1:0]                  status;
        logic                        last;
    } t_pen_beat;

    // DUT ports
    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_cfg_we      = 1'b0;
    logic [bbvs_pkg::PAPER_W-1:0]        i_cfg_wdata   = '0;
    logic                                start         = 1'b0;
    logic                                busy;
    logic [1:0]                          i_op          = bbvs_pkg::OP_APPEND;
    logic signed [bbvs_pkg::COORD_W-1:0] i_x_coord     = '0;
    logic signed [bbvs_pkg::COORD_W-1:0] i_y_coord     = '0;
    logic [bbvs_pkg::INDEX_W-1:0]        i_start_index = '0;
    logic [bbvs_pkg::INDEX_W-1:0]        i_end_index   = '0;
    logic                                o_strobe;
    logic                                o_pen_kind;
    logic [bbvs_pkg::QUOT_W-1:0]         o_graph_x;
    logic [bbvs_pkg::QUOT_W-1:0]         o_graph_y;
    logic [1:0]                          o_status;
    logic                                o_last;

    // plotter model state
    logic signed [bbvs_pkg::COORD_W-1:0] pt_x [STORE_DEPTH];
    logic signed [bbvs_pkg::COORD_W-1:0] pt_y [STORE_DEPTH];
    int unsigned                         pt_count = 0;
    logic signed [bbvs_pkg::COORD_W-1:0] x_min = '0, x_max = '0, y_min = '0, y_max = '0;
    logic [bbvs_pkg::PAPER_W-1:0]        paper = bbvs_pkg::PAPER_RESET;

    t_pen_beat pending_pen_beats[$];

    // bookkeeping
    int  err_count    = 0;
    int  beats_seen   = 0;
    int  live_items   = 0;
    int  lines_sent   = 0;
    int  appends_sent = 0;
    int  paper_writes = 0;
    int  stall_cycles = 0;
    bit  burst        = 1'b0;

    always #5 i_clk = ~i_clk;

    bounding_box_viewport_scaler_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_start_index (i_start_index),
        .i_end_index   (i_end_index),
        .o_strobe      (o_strobe),
        .o_pen_kind    (o_pen_kind),
        .o_graph_x     (o_graph_x),
        .o_graph_y     (o_graph_y),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    // (v - lo) * paper * 2^16 / (hi - lo), truncated
    function automatic logic [bbvs_pkg::QUOT_W-1:0] scale_to_paper(
        logic signed [bbvs_pkg::COORD_W-1:0] v,
        logic signed [bbvs_pkg::COORD_W-1:0] lo,
        logic signed [bbvs_pkg::COORD_W-1:0] hi);
        logic [63:0] diff, span, num;
        diff = 64'(longint'(v) - longint'(lo));
        span = 64'(longint'(hi) - longint'(lo));
        num  = (diff * 64'(paper)) << bbvs_pkg::FRAC_W;
        return bbvs_pkg::QUOT_W'(num / span);
    endfunction

    function automatic t_pen_beat plot_point(logic pen, logic [bbvs_pkg::INDEX_W-1:0] idx,
                                             logic is_last);
        t_pen_beat b;
        b.pen  = pen;
        b.gx   = '0;
        b.gy   = '0;
        b.last = is_last;
        if (idx >= pt_count) begin
            b.status = bbvs_pkg::STAT_NOT_LOADED;
        end else if (x_max == x_min || y_max == y_min) begin
            b.status = bbvs_pkg::STAT_ZERO_RANGE;
        end else begin
            b.status = bbvs_pkg::STAT_OK;
            b.gx     = scale_to_paper(pt_x[idx], x_min, x_max);
            b.gy     = scale_to_paper(pt_y[idx], y_min, y_max);
        end
        return b;
    endfunction

    // update model state for one accepted item and queue the beats it causes
    task automatic predict_plotter(logic [1:0] op, logic signed [bbvs_pkg::COORD_W-1:0] x,
                                   logic signed [bbvs_pkg::COORD_W-1:0] y,
                                   logic [bbvs_pkg::INDEX_W-1:0] s,
                                   logic [bbvs_pkg::INDEX_W-1:0] e);
        t_pen_beat full_beat;
        full_beat = '{pen: bbvs_pkg::PEN_MOVE, gx: '0, gy: '0,
                      status: bbvs_pkg::STAT_FULL, last: 1'b1};
        case (op)
            bbvs_pkg::OP_APPEND: begin
                appends_sent++;
                if (pt_count >= STORE_DEPTH) begin
                    pending_pen_beats.push_back(full_beat);
                end else begin
                    if (pt_count == 0) begin
                        x_min = x; x_max = x; y_min = y; y_max = y;
                    end else begin
                        if (x < x_min) x_min = x;
                        if (x > x_max) x_max = x;
                        if (y < y_min) y_min = y;
                        if (y > y_max) y_max = y;
                    end
                    pt_x[pt_count] = x;
                    pt_y[pt_count] = y;
                    pt_count++;
                end
            end
            bbvs_pkg::OP_LINE: begin
                lines_sent++;
                pending_pen_beats.push_back(plot_point(bbvs_pkg::PEN_MOVE, s, 1'b0));
                pending_pen_beats.push_back(plot_point(bbvs_pkg::PEN_DRAW, e, 1'b1));
            end
            bbvs_pkg::OP_CLEAR: begin
                pt_count = 0;
                x_min = '0; x_max = '0; y_min = '0; y_max = '0;
            end
            default: ;
        endcase
        if (op != OP_UNUSED) live_items++;
    endtask

    // drive one item, wait for it to be taken, then predict
    task automatic send_item(logic [1:0] op, logic signed [bbvs_pkg::COORD_W-1:0] x,
                             logic signed [bbvs_pkg::COORD_W-1:0] y,
                             logic [bbvs_pkg::INDEX_W-1:0] s,
                             logic [bbvs_pkg::INDEX_W-1:0] e);
        int gap;
        gap = burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_x_coord     <= x;
        i_y_coord     <= y;
        i_start_index <= s;
        i_end_index   <= e;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_plotter(op, x, y, s, e);
    endtask

    task automatic send_point(logic signed [bbvs_pkg::COORD_W-1:0] x,
                              logic signed [bbvs_pkg::COORD_W-1:0] y);
        send_item(bbvs_pkg::OP_APPEND, x, y, bbvs_pkg::INDEX_W'($urandom),
                  bbvs_pkg::INDEX_W'($urandom));
    endtask

    task automatic send_line(logic [bbvs_pkg::INDEX_W-1:0] s,
                             logic [bbvs_pkg::INDEX_W-1:0] e);
        send_item(bbvs_pkg::OP_LINE, $urandom, $urandom, s, e);
    endtask

    task automatic send_clear();
        send_item(bbvs_pkg::OP_CLEAR, $urandom, $urandom, bbvs_pkg::INDEX_W'($urandom),
                  bbvs_pkg::INDEX_W'($urandom));
    endtask

    task automatic send_unused();
        send_item(OP_UNUSED, $urandom, $urandom, bbvs_pkg::INDEX_W'($urandom),
                  bbvs_pkg::INDEX_W'($urandom));
    endtask

    // drop start, wait for all beats, then let any trailing work finish
    task automatic settle_idle();
        start <= 1'b0;
        while (pending_pen_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_paper(logic [bbvs_pkg::PAPER_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        paper = v;
        paper_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [bbvs_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return int'($urandom_range(0, 2000)) - 1000;
            3:       return int'($urandom_range(0, 3)) <<< bbvs_pkg::FRAC_W;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        if (err_count < MAX_REPORTS)
            $display("[%0t] MISMATCH beat %0d: %s", $realtime, beats_seen, msg);
        err_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // result checker: every strobed beat against the oldest expectation
    always @(posedge i_clk) begin
        t_pen_beat want;
        if (i_rst_n === 1'b1 && o_strobe !== 1'b0) begin
            if (pending_pen_beats.size() == 0) begin
                report_mismatch("beat with nothing expected");
            end else begin
                want = pending_pen_beats.pop_front();
                check_field("strobe", o_strobe, 1'b1);
                check_field("pen_kind", o_pen_kind, want.pen);
                check_field("graph_x", o_graph_x, want.gx);
                check_field("graph_y", o_graph_y, want.gy);
                check_field("status", o_status, want.status);
                check_field("last", o_last, want.last);
            end
            beats_seen++;
        end
    end

    // progress watchdog
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_pen_beats.size());
        $display("Verification failed");
        $finish;
    end

    // extremes, op 3, zero range and unloaded indices at reset paper size
    task automatic test_directed_basics();
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_line(0, 0);                         // single point: zero range
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_line(0, 1);
        send_line(1, 0);
        send_unused();
        send_point(0, 0);
        send_line(2, 2);
        send_line(0, 2);
        send_clear();
        send_point(5, 5);
        send_line(0, 1);                         // end index unloaded
        send_line(1, 0);                         // unloaded start, zero-range end
        send_point(5, 9);                        // same x: x range zero
        send_line(0, 1);
        send_line(2, 1);                         // unloaded beats zero range
        send_point(-7, 9);
        send_line(2, 0);
        settle_idle();
    endtask

    // paper size extremes, including zero
    task automatic test_paper_extremes();
        logic [bbvs_pkg::PAPER_W-1:0] sizes[4];
        sizes = '{8'd1, 8'd255, 8'd0, 8'd128};
        foreach (sizes[i]) begin
            write_paper(sizes[i]);
            send_clear();
            repeat (3) send_point(rand_coord(), rand_coord());
            send_line(0, 2);
            send_line(1, 1);
            settle_idle();
        end
    endtask

    // fill every entry, overflow it, then reach the top index loaded and unloaded
    task automatic test_store_full();
        write_paper(8'd255);
        send_clear();
        burst = 1'b1;
        repeat (STORE_DEPTH) send_point($urandom, $urandom);
        burst = 1'b0;
        send_point(rand_coord(), rand_coord());  // store full
        send_line(0, bbvs_pkg::INDEX_W'(STORE_DEPTH - 1));
        send_line(bbvs_pkg::INDEX_W'(STORE_DEPTH - 1), 512);
        send_clear();
        repeat (4) send_point(rand_coord(), rand_coord());
        send_line(bbvs_pkg::INDEX_W'(STORE_DEPTH - 1), 3);
        send_line(4, 0);
        settle_idle();
    endtask

    // sessions of clear, appends and lines with random content, plus noise
    task automatic test_random_sessions();
        int                                  base;
        int                                  since_cfg;
        bit                                  flat_x;
        logic signed [bbvs_pkg::COORD_W-1:0] fixed_x;
        base      = live_items;
        since_cfg = 0;
        while (live_items - base < RANDOM_ITEMS) begin
            if (since_cfg >= 60) begin
                settle_idle();
                case ($urandom_range(0, 3))
                    0:       write_paper(8'd1);
                    1:       write_paper(8'd255);
                    default: write_paper(bbvs_pkg::PAPER_W'($urandom_range(1, 255)));
                endcase
                since_cfg = 0;
            end
            burst   = ($urandom_range(0, 3) == 0);
            flat_x  = ($urandom_range(0, 7) == 0);
            fixed_x = rand_coord();
            since_cfg -= live_items;
            if ($urandom_range(0, 4) != 0) send_clear();
            repeat ($urandom_range(1, 24))
                send_point(flat_x ? fixed_x : rand_coord(), rand_coord());
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 9))
                    0:       send_unused();
                    1:       send_line(bbvs_pkg::INDEX_W'($urandom),
                                       bbvs_pkg::INDEX_W'($urandom));
                    default: send_line(bbvs_pkg::INDEX_W'($urandom_range(0, pt_count - 1)),
                                       bbvs_pkg::INDEX_W'($urandom_range(0, pt_count - 1)));
                endcase
            end
            since_cfg += live_items;
        end
        burst = 1'b0;
        settle_idle();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_paper_extremes();
        test_store_full();
        test_random_sessions();

        $display("Covered %0d items: %0d appends, %0d lines, %0d result beats checked",
                 live_items, appends_sent, lines_sent, beats_seen);
        $display("Paper size set %0d times (0, 1, 255 among them); store filled and overrun",
                 paper_writes);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
